>>> sv/efd_pkg.sv
// Shared constants, codes and the parsed-transaction record of the event frame deframer.
`default_nettype none
package efd_pkg;

  localparam int NUM_SOURCES_DEF  = 4;
  localparam int MAX_NAME_LEN_DEF = 32;
  localparam int MAX_DATA_LEN_DEF = 1024;
  localparam int HEADER_LEN       = 6;
  localparam int HDR_IDX_W        = $clog2(HEADER_LEN);

  localparam int SRC_ID_W  = 2;
  localparam int EVENT_W   = 3;
  localparam int ERR_W     = 2;
  localparam int LEN_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_US   = 8'h1F;
  localparam logic [7:0] ESC_XOR = 8'h20;

  localparam logic [EVENT_W-1:0] EV_HEADER = 3'd0;
  localparam logic [EVENT_W-1:0] EV_NAME   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DATA   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_END    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ERROR  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NO_STX   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NAME_OVF = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DATA_OVF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_RECEIVER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GROUP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ADDR  = 2'd2;

  typedef logic [HEADER_LEN-1:0][7:0] header_t;

  typedef struct packed {
    logic [SRC_ID_W-1:0] src;
    logic [EVENT_W-1:0]  ev;
    logic [7:0]          data;
    header_t             hdr;
    logic [LEN_W-1:0]    len;
    logic [ERR_W-1:0]    err;
  } rec_t;

endpackage
`default_nettype wire

>>> sv/event_frame_deframer_unit.sv
// Top level of the event frame deframer: front parser, transaction queue, back formatter.
//
//  channel   direction  handshake        payload
//  input     in         push / full      in_source_id, in_rx_byte
//  result    out        empty / pop      out_src_out .. out_error_code
//  config    in         cfg_we           cfg_index, cfg_data
//
// One byte is taken every cycle while full is low; the per-source parser updates in the cycle of the push.
// Each result is queued, then moves into the output register once it is empty or popped.
// full rises only once the four-entry queue and the output register are all occupied.
// Synchronous active-low reset returns every source to waiting for SOH, filters to 0xFF.
`default_nettype none
module event_frame_deframer_unit #(
  parameter int NUM_SOURCES  = efd_pkg::NUM_SOURCES_DEF,
  parameter int MAX_NAME_LEN = efd_pkg::MAX_NAME_LEN_DEF,
  parameter int MAX_DATA_LEN = efd_pkg::MAX_DATA_LEN_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            push,
  output logic                           full,
  input  wire [efd_pkg::SRC_ID_W-1:0]    in_source_id,
  input  wire [7:0]                      in_rx_byte,
  output logic                           empty,
  input  wire                            pop,
  output logic [efd_pkg::SRC_ID_W-1:0]   out_src_out,
  output logic [efd_pkg::EVENT_W-1:0]    out_event_res,
  output logic [7:0]                     out_byte_value,
  output logic [7:0]                     out_sender,
  output logic [7:0]                     out_receiver,
  output logic [7:0]                     out_group,
  output logic [7:0]                     out_flag_bits,
  output logic [15:0]                    out_msg_id,
  output logic [efd_pkg::LEN_W-1:0]      out_data_length,
  output logic                           out_accepted,
  output logic [efd_pkg::ERR_W-1:0]      out_error_code,
  input  wire                            cfg_we,
  input  wire [efd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [7:0]                      cfg_data
);
  import efd_pkg::*;

  logic accept;
  logic rec_valid;
  rec_t rec;
  logic head_valid;
  rec_t head_rec;
  logic head_pop;

  assign accept = push && !full;

  efd_front #(
    .NUM_SOURCES  (NUM_SOURCES),
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .MAX_DATA_LEN (MAX_DATA_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .source_id (in_source_id),
    .rx_byte   (in_rx_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  efd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (rec_valid),
    .wr_rec     (rec),
    .full       (full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  efd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head_valid      (head_valid),
    .head_rec        (head_rec),
    .head_pop        (head_pop),
    .empty           (empty),
    .pop             (pop),
    .out_src_out     (out_src_out),
    .out_event_res   (out_event_res),
    .out_byte_value  (out_byte_value),
    .out_sender      (out_sender),
    .out_receiver    (out_receiver),
    .out_group       (out_group),
    .out_flag_bits   (out_flag_bits),
    .out_msg_id      (out_msg_id),
    .out_data_length (out_data_length),
    .out_accepted    (out_accepted),
    .out_error_code  (out_error_code)
  );

endmodule
`default_nettype wire

>>> sv/efd_front.sv
// Front end: per-source unstuffing and frame parsing, one byte per cycle while accept is high.
`default_nettype none
module efd_front #(
  parameter int NUM_SOURCES  = efd_pkg::NUM_SOURCES_DEF,
  parameter int MAX_NAME_LEN = efd_pkg::MAX_NAME_LEN_DEF,
  parameter int MAX_DATA_LEN = efd_pkg::MAX_DATA_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire [efd_pkg::SRC_ID_W-1:0]  source_id,
  input  wire [7:0]                    rx_byte,
  output logic                         rec_valid,
  output efd_pkg::rec_t                rec
);
  import efd_pkg::*;

  localparam int SRC_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int EXT_W   = ((SRC_W > SRC_ID_W) ? SRC_W : SRC_ID_W) + 1;
  localparam int MAX_A   = (MAX_DATA_LEN > MAX_NAME_LEN) ? MAX_DATA_LEN : MAX_NAME_LEN;
  localparam int MAX_ALL = (MAX_A > HEADER_LEN) ? MAX_A : HEADER_LEN;
  localparam int CNT_W   = $clog2(MAX_ALL + 1);

  localparam logic [2:0] PH_SOH  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_STX  = 3'd2;
  localparam logic [2:0] PH_NAME = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0]       phase_r [NUM_SOURCES];
  logic             esc_r   [NUM_SOURCES];
  logic [CNT_W-1:0] cnt_r   [NUM_SOURCES];
  header_t          hdr_r   [NUM_SOURCES];

  logic [EXT_W-1:0]     src_ext;
  logic [SRC_W-1:0]     sel;
  logic                 in_range;
  logic                 upd;
  logic [2:0]           phase_cur, phase_nxt;
  logic                 esc_cur, esc_nxt;
  logic [CNT_W-1:0]     cnt_cur, cnt_nxt;
  header_t              hdr_cur;
  logic [7:0]           b_eff;
  logic                 lit;
  logic                 hdr_we;
  logic [CNT_W+LEN_W-1:0] cnt_ext;

  assign src_ext  = EXT_W'(source_id);
  assign sel      = src_ext[SRC_W-1:0];
  assign in_range = src_ext < EXT_W'(NUM_SOURCES);
  assign upd      = accept && in_range;

  assign phase_cur = phase_r[sel];
  assign esc_cur   = esc_r[sel];
  assign cnt_cur   = cnt_r[sel];
  assign hdr_cur   = hdr_r[sel];
  assign cnt_ext   = (CNT_W+LEN_W)'(cnt_cur);

  always_comb begin
    rec       = '0;
    rec.src   = source_id;
    rec.hdr   = hdr_cur;
    rec.len   = cnt_ext[LEN_W-1:0];
    rec_valid = 1'b0;
    phase_nxt = phase_cur;
    esc_nxt   = esc_cur;
    cnt_nxt   = cnt_cur;
    hdr_we    = 1'b0;
    b_eff     = rx_byte;
    lit       = 1'b0;
    if (upd) begin
      if (esc_cur) begin
        b_eff   = rx_byte ^ ESC_XOR;
        lit     = 1'b1;
        esc_nxt = 1'b0;
      end
      if (!esc_cur && rx_byte == CH_ESC) begin
        esc_nxt = 1'b1;
      end else begin
        rec.data = b_eff;
        unique case (phase_cur)
          PH_SOH: begin
            if (!lit && b_eff == CH_SOH) begin
              phase_nxt = PH_HDR;
              cnt_nxt   = '0;
            end
          end
          PH_HDR: begin
            hdr_we  = cnt_cur < CNT_W'(HEADER_LEN);
            cnt_nxt = cnt_cur + CNT_W'(1);
            if (cnt_cur + CNT_W'(1) >= CNT_W'(HEADER_LEN)) begin
              phase_nxt = PH_STX;
              cnt_nxt   = '0;
              rec_valid = 1'b1;
              rec.ev    = EV_HEADER;
              rec.hdr[HEADER_LEN-1] = b_eff;
            end
          end
          PH_STX: begin
            if (!lit && b_eff == CH_STX) begin
              phase_nxt = PH_NAME;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_SOH;
              esc_nxt   = 1'b0;
              cnt_nxt   = '0;
              rec_valid = 1'b1;
              rec.ev    = EV_ERROR;
              rec.err   = ERR_NO_STX;
            end
          end
          PH_NAME: begin
            if (!lit && b_eff == CH_US) begin
              phase_nxt = PH_DATA;
              cnt_nxt   = '0;
            end else if (cnt_cur >= CNT_W'(MAX_NAME_LEN)) begin
              phase_nxt = PH_SOH;
              esc_nxt   = 1'b0;
              cnt_nxt   = '0;
              rec_valid = 1'b1;
              rec.ev    = EV_ERROR;
              rec.err   = ERR_NAME_OVF;
            end else begin
              cnt_nxt   = cnt_cur + CNT_W'(1);
              rec_valid = 1'b1;
              rec.ev    = EV_NAME;
            end
          end
          PH_DATA: begin
            if (!lit && b_eff == CH_EOT) begin
              phase_nxt = PH_SOH;
              esc_nxt   = 1'b0;
              cnt_nxt   = '0;
              rec_valid = 1'b1;
              rec.ev    = EV_END;
            end else if (cnt_cur >= CNT_W'(MAX_DATA_LEN)) begin
              phase_nxt = PH_SOH;
              esc_nxt   = 1'b0;
              cnt_nxt   = '0;
              rec_valid = 1'b1;
              rec.ev    = EV_ERROR;
              rec.err   = ERR_DATA_OVF;
            end else begin
              cnt_nxt   = cnt_cur + CNT_W'(1);
              rec_valid = 1'b1;
              rec.ev    = EV_DATA;
            end
          end
          default: begin
            phase_nxt = PH_SOH;
            esc_nxt   = 1'b0;
            cnt_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        phase_r[s] <= PH_SOH;
        esc_r[s]   <= 1'b0;
        cnt_r[s]   <= '0;
      end
    end else if (upd) begin
      phase_r[sel] <= phase_nxt;
      esc_r[sel]   <= esc_nxt;
      cnt_r[sel]   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[sel][cnt_cur[HDR_IDX_W-1:0]] <= b_eff;
    end
  end

endmodule
`default_nettype wire

>>> sv/efd_queue.sv
// Short queue of parsed transactions between the front and back ends.
`default_nettype none
module efd_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            wr_en,
  input  efd_pkg::rec_t  wr_rec,
  output logic           full,
  input  wire            rd_en,
  output logic           head_valid,
  output efd_pkg::rec_t  head_rec
);
  import efd_pkg::*;

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (wr_en && !rd_en) count_r <= count_r + (QPTR_W+1)'(1);
      else if (rd_en && !wr_en) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_rec;
  end

endmodule
`default_nettype wire

>>> sv/efd_back.sv
// Back end: filter registers, result formatting and the output register.
`default_nettype none
module efd_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [efd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [7:0]                      cfg_data,
  input  wire                            head_valid,
  input  efd_pkg::rec_t                  head_rec,
  output logic                           head_pop,
  output logic                           empty,
  input  wire                            pop,
  output logic [efd_pkg::SRC_ID_W-1:0]   out_src_out,
  output logic [efd_pkg::EVENT_W-1:0]    out_event_res,
  output logic [7:0]                     out_byte_value,
  output logic [7:0]                     out_sender,
  output logic [7:0]                     out_receiver,
  output logic [7:0]                     out_group,
  output logic [7:0]                     out_flag_bits,
  output logic [15:0]                    out_msg_id,
  output logic [efd_pkg::LEN_W-1:0]      out_data_length,
  output logic                           out_accepted,
  output logic [efd_pkg::ERR_W-1:0]      out_error_code
);
  import efd_pkg::*;

  logic [7:0] filt_rcv_r, filt_grp_r, bcast_r;
  logic       valid_r;
  logic       is_hdr, is_end, is_byte, is_err;

  function automatic logic addr_ok(input logic [7:0] filt, input logic [7:0] hdr,
                                   input logic [7:0] bc);
    return (filt == bc) || (hdr == bc) || (filt == hdr);
  endfunction

  assign head_pop = head_valid && (!valid_r || pop);
  assign empty    = !valid_r;

  assign is_end  = head_rec.ev == EV_END;
  assign is_hdr  = (head_rec.ev == EV_HEADER) || is_end;
  assign is_byte = (head_rec.ev == EV_NAME) || (head_rec.ev == EV_DATA);
  assign is_err  = head_rec.ev == EV_ERROR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_rcv_r <= 8'hFF;
      filt_grp_r <= 8'hFF;
      bcast_r    <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_RECEIVER: filt_rcv_r <= cfg_data;
        REG_FILTER_GROUP:    filt_grp_r <= cfg_data;
        REG_BROADCAST_ADDR:  bcast_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (head_pop) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      out_src_out     <= head_rec.src;
      out_event_res   <= head_rec.ev;
      out_byte_value  <= is_byte ? head_rec.data : 8'h00;
      out_sender      <= is_hdr ? head_rec.hdr[0] : 8'h00;
      out_receiver    <= is_hdr ? head_rec.hdr[1] : 8'h00;
      out_group       <= is_hdr ? head_rec.hdr[2] : 8'h00;
      out_flag_bits   <= is_hdr ? head_rec.hdr[3] : 8'h00;
      out_msg_id      <= is_hdr ? {head_rec.hdr[4], head_rec.hdr[5]} : 16'h0000;
      out_data_length <= is_end ? head_rec.len : '0;
      out_accepted    <= is_end && addr_ok(filt_rcv_r, head_rec.hdr[1], bcast_r)
                                && addr_ok(filt_grp_r, head_rec.hdr[2], bcast_r);
      out_error_code  <= is_err ? head_rec.err : '0;
    end
  end

endmodule
`default_nettype wire
